@@ hdl/joystick_axis_conditioner_assert.svh @@
// Assertion macros shared by the joystick axis conditioner RTL.
`ifndef JOYSTICK_AXIS_CONDITIONER_ASSERT_SVH
`define JOYSTICK_AXIS_CONDITIONER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define JAC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define JAC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/jac_pkg.sv @@
// Types and constants shared by the joystick axis conditioner modules.
`timescale 1ns / 1ps

package jac_pkg;

    localparam int AXES       = 4;
    localparam int SAMPLE_W   = 12;
    localparam int FILT_W     = 13;
    localparam int AXIS_W     = 8;
    localparam int DEADZONE_W = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_LX = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_LY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_RX = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_RY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEADZONE  = 3'd4;

    localparam logic [SAMPLE_W-1:0]   CENTER_RESET   = 12'd2048;
    localparam logic [DEADZONE_W-1:0] DEADZONE_RESET = 7'd20;
    localparam logic [AXIS_W-2:0]     AXIS_MAX       = 7'd127;

    typedef logic signed [AXIS_W-1:0] axis_t;

    // Pipeline strobes: a request enters the lanes, a lane result moves to the output.
    typedef struct packed {
        logic accept;
        logic advance;
    } jac_pipe_t;

endpackage

@@ hdl/jac_lane.sv @@
// One axis lane: centring, moving-average update and output conditioning.
`timescale 1ns / 1ps

module jac_lane #(
    parameter int SMOOTH_DIVISOR = 5
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  jac_pkg::jac_pipe_t                  pipe,
    input  logic [jac_pkg::SAMPLE_W-1:0]        sample,
    input  logic [jac_pkg::SAMPLE_W-1:0]        center,
    input  logic [jac_pkg::DEADZONE_W-1:0]      deadzone,
    output jac_pkg::axis_t                      axis
);
    import jac_pkg::*;

    // Reciprocal of the divisor, exact for every difference magnitude below 2^24.
    localparam int RECIP_SHIFT = 28;
    localparam int RECIP_W     = 28;
    localparam int MAG_W       = FILT_W;
    localparam int PROD_W      = MAG_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + SMOOTH_DIVISOR - 1) / SMOOTH_DIVISOR);

    logic signed [FILT_W-1:0]   filter_reg;
    logic signed [FILT_W-1:0]   filter_next;
    logic signed [FILT_W-1:0]   centered;
    logic signed [FILT_W:0]     diff;
    logic [MAG_W-1:0]           diff_mag;
    logic [PROD_W-1:0]          prod;
    logic [MAG_W-1:0]           quot;
    logic signed [FILT_W:0]     step;
    logic signed [FILT_W:0]     sum;
    logic [FILT_W-1:0]          avg_mag;
    logic [FILT_W-5:0]          scaled;
    logic [AXIS_W-2:0]          sat;

    always_comb begin
        centered = $signed({1'b0, sample}) - $signed({1'b0, center});
        diff     = {centered[FILT_W-1], centered} - {filter_reg[FILT_W-1], filter_reg};
        diff_mag = diff[FILT_W] ? MAG_W'(-diff) : MAG_W'(diff);
        prod     = PROD_W'(diff_mag) * PROD_W'(RECIP);
        quot     = prod[RECIP_SHIFT +: MAG_W];
        // Truncate toward zero: divide the magnitude, then restore the sign.
        step     = diff[FILT_W] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
        sum      = {filter_reg[FILT_W-1], filter_reg} + step;
        filter_next = sum[FILT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_reg <= '0;
        end else if (pipe.accept) begin
            filter_reg <= filter_next;
        end
    end

    // Scale the stored average by sixteen toward zero, apply deadzone, saturate.
    always_comb begin
        avg_mag = filter_reg[FILT_W-1] ? FILT_W'(-filter_reg) : FILT_W'(filter_reg);
        scaled  = avg_mag[FILT_W-1:4];
        if (scaled < (FILT_W-4)'(deadzone)) begin
            sat = '0;
        end else if (scaled > (FILT_W-4)'(AXIS_MAX)) begin
            sat = AXIS_MAX;
        end else begin
            sat = scaled[AXIS_W-2:0];
        end
        axis = filter_reg[FILT_W-1] ? -$signed({1'b0, sat}) : $signed({1'b0, sat});
    end

endmodule

@@ hdl/jac_merge.sv @@
// Output register that gathers the four lane results into one result word.
`timescale 1ns / 1ps

module jac_merge (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  jac_pkg::jac_pipe_t                     pipe,
    input  jac_pkg::axis_t [jac_pkg::AXES-1:0]     lane_axis,
    input  logic                                   m_tready,
    output logic                                   m_tvalid,
    output logic [jac_pkg::AXES*jac_pkg::AXIS_W-1:0] m_tdata,
    output logic                                   out_free
);
    import jac_pkg::*;

    logic                     m_tvalid_reg;
    logic                     m_tvalid_next;
    logic [AXES*AXIS_W-1:0]   m_tdata_reg;

    assign out_free      = !m_tvalid_reg || m_tready;
    assign m_tvalid_next = pipe.advance || (m_tvalid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe.advance) begin
            for (int i = 0; i < AXES; i++) begin
                m_tdata_reg[i*AXIS_W +: AXIS_W] <= lane_axis[i];
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ hdl/joystick_axis_conditioner.sv @@
// Top level of the joystick axis conditioner: config registers, lanes, output.
`timescale 1ns / 1ps
//
// Conditions one scan of four 12-bit joystick ADC samples per request into
// four signed 8-bit axis values (left X, left Y, right X, right Y).
// Input stream s_*: s_tdata carries the four samples, 12 bits each.
// Output stream m_*: m_tdata carries the four axis bytes, -127..127 each.
// Config channel cfg_*: index 0..3 sets the centre of each axis, index 4 the
// deadzone; other indexes are dropped. cfg_ready is always high; write only
// while no request is in flight.
// Four lanes run in parallel, one per axis. Each holds its moving average and
// updates it in the cycle a request is taken (subtract, reciprocal multiply,
// add). The conditioned value of the new average is held pending in the lanes
// and is loaded into the output register once that register is free, and one
// request is taken every cycle while the output drains.
// The average update loop sets the rate.
// If m_tready stays low, one result waits in the lanes and one in the output
// register; s_tready then drops until the output moves.
// Reset clears all averages to zero, all centres to 2048, deadzone to 20,
// and empties the pipeline.
//
module joystick_axis_conditioner #(
    parameter int SMOOTH_DIVISOR = 5
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    // s_tdata: sample_left_x, sample_left_y, sample_right_x, sample_right_y
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    input  logic [jac_pkg::AXES*jac_pkg::SAMPLE_W-1:0]  s_tdata,
    // m_tdata: axis_left_x, axis_left_y, axis_right_x, axis_right_y
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    output logic [jac_pkg::AXES*jac_pkg::AXIS_W-1:0]    m_tdata,
    input  logic                                        cfg_valid,
    output logic                                        cfg_ready,
    input  logic [jac_pkg::CFG_IDX_W-1:0]               cfg_index,
    input  logic [jac_pkg::CFG_DATA_W-1:0]              cfg_data
);
    import jac_pkg::*;

    logic [SAMPLE_W-1:0]        center_reg [AXES];
    logic [DEADZONE_W-1:0]      deadzone_reg;
    logic                       pend_reg;
    logic                       pend_next;
    logic                       out_free;
    jac_pipe_t                  pipe;
    axis_t [AXES-1:0]           lane_axis;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < AXES; i++) begin
                center_reg[i] <= CENTER_RESET;
            end
            deadzone_reg <= DEADZONE_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_CENTER_LX: center_reg[0] <= cfg_data;
                REG_CENTER_LY: center_reg[1] <= cfg_data;
                REG_CENTER_RX: center_reg[2] <= cfg_data;
                REG_CENTER_RY: center_reg[3] <= cfg_data;
                REG_DEADZONE:  deadzone_reg  <= cfg_data[DEADZONE_W-1:0];
                default: ;
            endcase
        end
    end

    // A lane result is pending until the output register takes it.
    assign pipe.advance = pend_reg && out_free;
    assign s_tready     = !pend_reg || out_free;
    assign pipe.accept  = s_tvalid && s_tready;
    assign pend_next    = pipe.accept || (pend_reg && !out_free);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    for (genvar g = 0; g < AXES; g++) begin : g_lane
        jac_lane #(
            .SMOOTH_DIVISOR (SMOOTH_DIVISOR)
        ) u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .pipe     (pipe),
            .sample   (s_tdata[g*SAMPLE_W +: SAMPLE_W]),
            .center   (center_reg[g]),
            .deadzone (deadzone_reg),
            .axis     (lane_axis[g])
        );
    end

    jac_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pipe      (pipe),
        .lane_axis (lane_axis),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .out_free  (out_free)
    );

`include "joystick_axis_conditioner_assert.svh"

    `JAC_ASSERT_NEXT(a_accept_pends, aclk, aresetn, pipe.accept, pend_reg, "accepted request not pending")
    `JAC_ASSERT_NEXT(a_advance_shows, aclk, aresetn, pipe.advance, m_tvalid, "advanced result not presented")
    `JAC_ASSERT_NOW(a_no_wrap, aclk, aresetn, m_tvalid, (m_tdata[7:0] != 8'h80) && (m_tdata[15:8] != 8'h80) && (m_tdata[23:16] != 8'h80) && (m_tdata[31:24] != 8'h80), "axis value outside saturation range")

endmodule

@@ tb/joystick_axis_conditioner_test.sv @@
// Self-checking stream testbench for the joystick axis conditioner.
`timescale 1ns / 1ps

module joystick_axis_conditioner_test;
    import jac_pkg::*;

    localparam int SMOOTH        = 5;
    localparam int SCALE_DIV     = 16;
    localparam int SCAN_W        = AXES * SAMPLE_W;
    localparam int RESULT_W      = AXES * AXIS_W;
    localparam int SAMPLE_MAX    = (1 << SAMPLE_W) - 1;
    localparam int LATENCY       = 2;
    localparam int LIMIT_CYCLES  = 200000;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_SCANS   = 110;
    localparam int REPORT_MAX    = 10;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [SCAN_W-1:0]     s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [RESULT_W-1:0]   m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_CENTER_LX;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Predictor state and register copies
    int centre_set [AXES];
    int deadzone_set;
    int average [AXES];

    logic [SCAN_W-1:0]   scans_waiting [$];
    logic [RESULT_W-1:0] axes_due [$];
    int                  fail_count = 0;
    int                  cycles = 0;
    bit                  steady = 1'b0;

    joystick_axis_conditioner #(
        .SMOOTH_DIVISOR(SMOOTH)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic void log_fault(string msg);
        if (fail_count < REPORT_MAX) begin
            $display("MISMATCH at cycle %0d: %s", cycles, msg);
        end
        fail_count++;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_CENTER_LX, REG_CENTER_LY, REG_CENTER_RX, REG_CENTER_RY: begin
                centre_set[idx] = int'(data);
            end
            REG_DEADZONE: begin
                deadzone_set = int'(data[DEADZONE_W-1:0]);
            end
            default: ;
        endcase
    endfunction

    // Update every axis average and return the conditioned axis bytes.
    function automatic logic [RESULT_W-1:0] condition_scan(logic [SCAN_W-1:0] scan);
        int                  sample;
        int                  centred;
        int                  scaled;
        int                  mag;
        logic [RESULT_W-1:0] axes;
        for (int a = 0; a < AXES; a++) begin
            sample     = int'(scan[a*SAMPLE_W +: SAMPLE_W]);
            centred    = sample - centre_set[a];
            average[a] = average[a] + (centred - average[a]) / SMOOTH;
            scaled     = average[a] / SCALE_DIV;
            mag        = scaled < 0 ? -scaled : scaled;
            if (mag < deadzone_set) begin
                scaled = 0;
            end
            if (scaled > int'(AXIS_MAX)) begin
                scaled = int'(AXIS_MAX);
            end
            if (scaled < -int'(AXIS_MAX)) begin
                scaled = -int'(AXIS_MAX);
            end
            axes[a*AXIS_W +: AXIS_W] = scaled[AXIS_W-1:0];
        end
        return axes;
    endfunction

    function automatic logic [SCAN_W-1:0] make_scan(int lx, int ly, int rx, int ry);
        return {ry[SAMPLE_W-1:0], rx[SAMPLE_W-1:0], ly[SAMPLE_W-1:0], lx[SAMPLE_W-1:0]};
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        apply_reg(idx, data);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_settled();
        do @(negedge aclk); while (scans_waiting.size() != 0 || s_tvalid || axes_due.size() != 0);
    endtask

    // Pick new register values; the first phase pins the deadzone at its top.
    task automatic shuffle_config(int phase);
        logic [CFG_DATA_W-1:0] data;
        for (int r = int'(REG_CENTER_LX); r <= int'(REG_DEADZONE); r++) begin
            if (phase == 0 || $urandom_range(1) == 1) begin
                if (r == int'(REG_DEADZONE)) begin
                    case ($urandom_range(3))
                        0:       data = '0;
                        1:       data = 12'd127;
                        default: data = CFG_DATA_W'($urandom_range(SAMPLE_MAX));
                    endcase
                    if (phase == 0) begin
                        data = 12'd127;
                    end
                end else begin
                    case ($urandom_range(4))
                        0:       data = '0;
                        1:       data = CFG_DATA_W'(SAMPLE_MAX);
                        2:       data = CFG_DATA_W'(int'(CENTER_RESET)
                                                    + int'($urandom_range(64)) - 32);
                        default: data = CFG_DATA_W'($urandom_range(SAMPLE_MAX));
                    endcase
                end
                write_reg(r[CFG_IDX_W-1:0], data);
            end
        end
        if ($urandom_range(3) == 0) begin
            write_reg(REG_DEADZONE + CFG_IDX_W'($urandom_range(1, 3)),
                      CFG_DATA_W'($urandom_range(SAMPLE_MAX)));
        end
    endtask

    // Hold each axis near a target for a run of scans, with some pure noise.
    task automatic queue_phase(int count);
        int target [AXES];
        int run_left = 0;
        int noise;
        int sample;
        logic [SCAN_W-1:0] scan;
        @(negedge aclk);
        for (int n = 0; n < count; n++) begin
            if (run_left == 0) begin
                run_left = int'($urandom_range(3, 30));
                foreach (target[a]) begin
                    case ($urandom_range(5))
                        0:       target[a] = 0;
                        1:       target[a] = SAMPLE_MAX;
                        2:       target[a] = centre_set[a];
                        default: target[a] = int'($urandom_range(SAMPLE_MAX));
                    endcase
                end
            end
            run_left--;
            if ($urandom_range(9) == 0) begin
                scan = SCAN_W'({$urandom, $urandom});
            end else begin
                for (int a = 0; a < AXES; a++) begin
                    noise  = int'($urandom_range(80));
                    sample = target[a] + noise - 40;
                    if (sample < 0) sample = 0;
                    if (sample > SAMPLE_MAX) sample = SAMPLE_MAX;
                    scan[a*SAMPLE_W +: SAMPLE_W] = sample[SAMPLE_W-1:0];
                end
            end
            scans_waiting.push_back(scan);
        end
    endtask

    // Request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                axes_due.push_back(condition_scan(s_tdata));
            end
            if (!s_tvalid || s_tready) begin
                if (scans_waiting.size() != 0 && (steady || $urandom_range(99) >= 8)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= scans_waiting.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        logic [RESULT_W-1:0] due;
        m_tready <= steady || $urandom_range(99) >= 8;
        if (aresetn && m_tvalid && m_tready) begin
            if (axes_due.size() == 0) begin
                log_fault($sformatf("result %h with none expected", m_tdata));
            end else begin
                due = axes_due.pop_front();
                for (int a = 0; a < AXES; a++) begin
                    if (m_tdata[a*AXIS_W +: AXIS_W] !== due[a*AXIS_W +: AXIS_W]) begin
                        log_fault($sformatf("axis %0d expected %0d, got %0d", a,
                                  $signed(due[a*AXIS_W +: AXIS_W]),
                                  $signed(m_tdata[a*AXIS_W +: AXIS_W])));
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        foreach (centre_set[a]) begin
            centre_set[a] = int'(CENTER_RESET);
            average[a]    = 0;
        end
        deadzone_set = int'(DEADZONE_RESET);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: field extremes and alternating bit patterns
        @(negedge aclk);
        repeat (3) scans_waiting.push_back(make_scan(0, 0, 0, 0));
        repeat (3) scans_waiting.push_back(make_scan(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX));
        scans_waiting.push_back(make_scan('hAAA, 'h555, 'hAAA, 'h555));
        scans_waiting.push_back(make_scan('h555, 'hAAA, 'h555, int'(CENTER_RESET)));
        wait_settled();

        // Extreme centres, zero deadzone: drive both saturation limits
        write_reg(REG_CENTER_LX, '0);
        write_reg(REG_CENTER_LY, '0);
        write_reg(REG_CENTER_RX, CFG_DATA_W'(SAMPLE_MAX));
        write_reg(REG_CENTER_RY, CFG_DATA_W'(SAMPLE_MAX));
        write_reg(REG_DEADZONE, '0);
        write_reg(REG_DEADZONE + 3'd1, 12'hFFF);
        write_reg(REG_DEADZONE + 3'd3, 12'h123);
        @(negedge aclk);
        repeat (6) scans_waiting.push_back(make_scan(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX));
        repeat (6) scans_waiting.push_back(make_scan(0, 0, 0, 0));
        wait_settled();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            shuffle_config(p);
            steady = (p == RANDOM_PHASES / 2);
            queue_phase(PHASE_SCANS);
            wait_settled();
        end
        steady = 1'b0;

        repeat (LATENCY + 8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
